// ----- hw/rtl/ssd_pkg.sv -----
package ssd_pkg;

  // sample format
  localparam int SAMPLE_BITS = 24;
  localparam int SFRAC       = SAMPLE_BITS - 1;

  // gain format, unsigned Q4.12
  localparam int GAIN_BITS = 16;
  localparam int GAIN_FRAC = 12;

  // shaping precision
  localparam int WORK_FRAC = 31;
  localparam int ROOT_BITS = WORK_FRAC + 1;
  localparam int RAD_BITS  = 2 * WORK_FRAC + 1;
  localparam int RES_BITS  = RAD_BITS + 1;
  localparam int SQRT_STEPS = WORK_FRAC + 1;
  localparam int CNT_BITS  = $clog2(SQRT_STEPS);

  // product of magnitude and gain
  localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
  localparam int PFRAC     = SFRAC + GAIN_FRAC;
  localparam int MAG_SHR   = (PFRAC >= WORK_FRAC) ? PFRAC - WORK_FRAC : 0;
  localparam int MAG_SHL   = (PFRAC < WORK_FRAC) ? WORK_FRAC - PFRAC : 0;
  localparam int MAG_BITS  = PFRAC + MAG_SHL;

  // shaped value, dither and rounding
  localparam int Y_BITS     = ROOT_BITS + 1;
  localparam int DITH_SHIFT = SFRAC + 1;
  localparam int DITH_BITS  = 33 - DITH_SHIFT;
  localparam int SUM_BITS   = Y_BITS + 1;
  localparam int OSHIFT     = WORK_FRAC - SFRAC;
  localparam int Q_BITS     = SUM_BITS - OSHIFT;

  // generator
  localparam logic [31:0] DITH_MID = 32'h7fff_ffff;

  // configuration port
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;
  localparam logic [1:0] REG_GAIN       = 2'd0;
  localparam logic [1:0] REG_SEED_LEFT  = 2'd1;
  localparam logic [1:0] REG_SEED_RIGHT = 2'd2;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET       = 16'd4096;
  localparam logic [31:0]          SEED_LEFT_RESET  = 32'd2463534242;
  localparam logic [31:0]          SEED_RIGHT_RESET = 32'd1812433253;

  typedef struct packed {
    logic                start;
    logic [RAD_BITS-1:0] operand;
  } sqrt_ctrl_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [ROOT_BITS-1:0] root;
  } sqrt_stat_t;

  typedef struct packed {
    logic step_left;
    logic step_right;
  } dither_step_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0] gain;
    logic [31:0]          state_left;
    logic [31:0]          state_right;
  } cfg_t;

  // one xorshift32 step (13, 17, 5)
  function automatic logic [31:0] xs32(input logic [31:0] s);
    logic [31:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

endpackage

// ----- hw/rtl/ssd_isqrt.sv -----
module ssd_isqrt (
  input  logic               clk,
  input  logic               rst,
  input  ssd_pkg::sqrt_ctrl_t ctrl,
  output ssd_pkg::sqrt_stat_t stat
);

  logic [ssd_pkg::RAD_BITS-1:0] rem;
  logic [ssd_pkg::RES_BITS-1:0] res;
  logic [ssd_pkg::RAD_BITS-1:0] bitw;
  logic [ssd_pkg::CNT_BITS-1:0] cnt;
  logic                         busy;
  logic                         done;

  logic [ssd_pkg::RES_BITS-1:0] trial;
  logic                         take;

  // one digit per cycle: trial subtract of res + bit
  assign trial = res + ssd_pkg::RES_BITS'(bitw);
  assign take  = ssd_pkg::RES_BITS'(rem) >= trial;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= ssd_pkg::CNT_BITS'(ssd_pkg::SQRT_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem  <= ctrl.operand;
      res  <= '0;
      bitw <= ssd_pkg::RAD_BITS'(1) << (2 * ssd_pkg::WORK_FRAC);
    end else if (busy) begin
      if (take) begin
        rem <= rem - ssd_pkg::RAD_BITS'(trial);
        res <= (res >> 1) + ssd_pkg::RES_BITS'(bitw);
      end else begin
        res <= res >> 1;
      end
      bitw <= bitw >> 2;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.root = res[ssd_pkg::ROOT_BITS-1:0];

endmodule

// ----- hw/rtl/ssd_regs.sv -----
module ssd_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ssd_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [ssd_pkg::DATA_BITS-1:0]   pwdata,
  output logic [ssd_pkg::DATA_BITS-1:0]   prdata,
  input  ssd_pkg::dither_step_t           step,
  output ssd_pkg::cfg_t                   cfg
);

  logic [ssd_pkg::GAIN_BITS-1:0] gain;
  logic [31:0]                   seed_left;
  logic [31:0]                   seed_right;
  logic [31:0]                   state_left;
  logic [31:0]                   state_right;
  logic                          wr;
  logic [1:0]                    idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[3:2];

  // registers and generator states; a seed write reloads its generator
  always_ff @(posedge clk) begin
    if (rst) begin
      gain        <= ssd_pkg::GAIN_RESET;
      seed_left   <= ssd_pkg::SEED_LEFT_RESET;
      seed_right  <= ssd_pkg::SEED_RIGHT_RESET;
      state_left  <= ssd_pkg::SEED_LEFT_RESET;
      state_right <= ssd_pkg::SEED_RIGHT_RESET;
    end else begin
      if (step.step_left) begin
        state_left <= ssd_pkg::xs32(state_left);
      end
      if (step.step_right) begin
        state_right <= ssd_pkg::xs32(state_right);
      end
      if (wr) begin
        unique case (idx)
          ssd_pkg::REG_GAIN: begin
            gain <= pwdata[ssd_pkg::GAIN_BITS-1:0];
          end
          ssd_pkg::REG_SEED_LEFT: begin
            seed_left  <= pwdata;
            state_left <= pwdata;
          end
          ssd_pkg::REG_SEED_RIGHT: begin
            seed_right  <= pwdata;
            state_right <= pwdata;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      ssd_pkg::REG_GAIN:       prdata = ssd_pkg::DATA_BITS'(gain);
      ssd_pkg::REG_SEED_LEFT:  prdata = seed_left;
      ssd_pkg::REG_SEED_RIGHT: prdata = seed_right;
      default:                 prdata = '0;
    endcase
  end

  assign cfg.gain        = gain;
  assign cfg.state_left  = state_left;
  assign cfg.state_right = state_right;

endmodule

// ----- hw/rtl/stereo_sqrt_saturator_dither.sv -----
// Stereo soft saturator with xorshift32 dither. One request carries a left and a right
// Q1.23 sample; each is scaled by the Q4.12 gain, clipped to full scale, shaped by
// 1 - sqrt(1 - |x|) with its sign restored, dithered by half an LSB from its own
// xorshift32 generator and saturated to 24 bits. Both channels share one square root
// unit that resolves one root bit per cycle, first for the left channel and then for
// the right. A new frame is taken only while the block is idle; the result register
// holds until taken, and the block may accept the next frame while it waits. Writing
// a seed register reloads that generator at once.
module stereo_sqrt_saturator_dither (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [ssd_pkg::SAMPLE_BITS-1:0] sample_left,
  input  logic signed [ssd_pkg::SAMPLE_BITS-1:0] sample_right,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ssd_pkg::SAMPLE_BITS-1:0] out_left,
  output logic signed [ssd_pkg::SAMPLE_BITS-1:0] out_right,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ssd_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [ssd_pkg::DATA_BITS-1:0]        pwdata,
  output logic [ssd_pkg::DATA_BITS-1:0]        prdata,
  output logic                                 pready
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_SQRT  = 7'b0001000,
    S_SHAPE = 7'b0010000,
    S_QUANT = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  ssd_pkg::cfg_t         cfg;
  ssd_pkg::dither_step_t step;
  ssd_pkg::sqrt_ctrl_t   sq_ctrl;
  ssd_pkg::sqrt_stat_t   sq_stat;

  logic                                 ch;
  logic signed [ssd_pkg::SAMPLE_BITS-1:0] smp_left;
  logic signed [ssd_pkg::SAMPLE_BITS-1:0] smp_right;
  logic                                 neg;
  logic [ssd_pkg::PROD_BITS-1:0]        prod;
  logic signed [ssd_pkg::Y_BITS-1:0]    y_s;
  logic signed [ssd_pkg::DITH_BITS-1:0] dith;
  logic signed [ssd_pkg::SAMPLE_BITS-1:0] res_left;
  logic signed [ssd_pkg::SAMPLE_BITS-1:0] res_right;

  logic                                 in_acc;
  logic                                 out_free;
  logic signed [ssd_pkg::SAMPLE_BITS-1:0] x_sel;
  logic [ssd_pkg::SAMPLE_BITS-1:0]      x_abs;
  logic                                 clip;
  logic [ssd_pkg::MAG_BITS-1:0]         mag_ext;
  logic [ssd_pkg::ROOT_BITS-1:0]        mag_w;
  logic [ssd_pkg::ROOT_BITS-1:0]        one_minus;
  logic [ssd_pkg::ROOT_BITS-1:0]        y_mag;
  logic [31:0]                          st_next;
  logic signed [32:0]                   d;
  logic signed [ssd_pkg::SUM_BITS-1:0]  sum;
  logic signed [ssd_pkg::Q_BITS-1:0]    q;
  logic signed [ssd_pkg::SAMPLE_BITS-1:0] q_sat;

  localparam logic [ssd_pkg::ROOT_BITS-1:0] ONE =
    ssd_pkg::ROOT_BITS'(1) << ssd_pkg::WORK_FRAC;

  assign pready   = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  ssd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .step    (step),
    .cfg     (cfg)
  );

  ssd_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .ctrl (sq_ctrl),
    .stat (sq_stat)
  );

  // magnitude of the selected channel
  assign x_sel = ch ? smp_right : smp_left;
  assign x_abs = x_sel[ssd_pkg::SAMPLE_BITS-1] ? ssd_pkg::SAMPLE_BITS'(-x_sel)
                                               : ssd_pkg::SAMPLE_BITS'(x_sel);

  // clip and align to the working fraction, then form (1 - x) << WORK_FRAC
  assign clip    = |prod[ssd_pkg::PROD_BITS-1:ssd_pkg::PFRAC];
  assign mag_ext = ssd_pkg::MAG_BITS'(prod[ssd_pkg::PFRAC-1:0]) << ssd_pkg::MAG_SHL;
  assign mag_w   = clip ? ONE : ssd_pkg::ROOT_BITS'(mag_ext >> ssd_pkg::MAG_SHR);
  assign one_minus = ONE - mag_w;

  assign sq_ctrl.start   = (state == S_LOAD);
  assign sq_ctrl.operand = {one_minus, ssd_pkg::WORK_FRAC'(0)};

  // shaped value and dither
  assign y_mag   = ONE - sq_stat.root;
  assign st_next = ssd_pkg::xs32(ch ? cfg.state_right : cfg.state_left);
  assign d       = $signed({1'b0, st_next}) - $signed({1'b0, ssd_pkg::DITH_MID});

  assign step.step_left  = (state == S_SHAPE) && !ch;
  assign step.step_right = (state == S_SHAPE) && ch;

  // add dither, floor to the output grid, saturate
  assign sum = ssd_pkg::SUM_BITS'(y_s) + ssd_pkg::SUM_BITS'(dith);
  assign q   = ssd_pkg::Q_BITS'(sum >>> ssd_pkg::OSHIFT);

  always_comb begin
    if ((&q[ssd_pkg::Q_BITS-1:ssd_pkg::SFRAC]) || !(|q[ssd_pkg::Q_BITS-1:ssd_pkg::SFRAC])) begin
      q_sat = q[ssd_pkg::SAMPLE_BITS-1:0];
    end else if (q[ssd_pkg::Q_BITS-1]) begin
      q_sat = {1'b1, {ssd_pkg::SFRAC{1'b0}}};
    end else begin
      q_sat = {1'b0, {ssd_pkg::SFRAC{1'b1}}};
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_acc) state_next = S_MUL;
      S_MUL:   state_next = S_LOAD;
      S_LOAD:  state_next = S_SQRT;
      S_SQRT:  if (sq_stat.done) state_next = S_SHAPE;
      S_SHAPE: state_next = S_QUANT;
      S_QUANT: state_next = ch ? S_OUT : S_MUL;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        ch <= 1'b0;
      end else if (state == S_QUANT) begin
        ch <= 1'b1;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_left  <= sample_left;
      smp_right <= sample_right;
    end
    if (state == S_MUL) begin
      neg  <= x_sel[ssd_pkg::SAMPLE_BITS-1];
      prod <= ssd_pkg::PROD_BITS'(x_abs) * ssd_pkg::PROD_BITS'(cfg.gain);
    end
    if (state == S_SHAPE) begin
      y_s  <= neg ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});
      dith <= ssd_pkg::DITH_BITS'(d >>> ssd_pkg::DITH_SHIFT);
    end
    if (state == S_QUANT) begin
      if (ch) begin
        res_right <= q_sat;
      end else begin
        res_left <= q_sat;
      end
    end
    if (state == S_OUT && out_free) begin
      out_left  <= res_left;
      out_right <= res_right;
    end
  end

  // checks
  a_accept_starts : assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_MUL && !ch))
    else $error("accepted frame did not start on the left channel");

  a_start_idle : assert property (@(posedge clk) disable iff (rst)
    sq_ctrl.start |-> !sq_stat.busy)
    else $error("root unit started while busy");

  a_done_in_sqrt : assert property (@(posedge clk) disable iff (rst)
    sq_stat.done |-> (state == S_SQRT))
    else $error("root finished outside the wait step");

  a_out_from_seq : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result presented without a finished frame");

endmodule

// ----- tb/sv/stereo_sqrt_saturator_dither_test.sv -----
`timescale 1ns / 100ps

module stereo_sqrt_saturator_dither_test;

  localparam int SB        = ssd_pkg::SAMPLE_BITS;
  localparam int FRAC_W    = 31;            // shaping fraction bits
  localparam int FRAC_S    = SB - 1;        // sample fraction bits
  localparam int FRAC_P    = FRAC_S + 12;   // fraction bits of sample * Q4.12 gain
  localparam int OUT_SHIFT = FRAC_W - FRAC_S;
  localparam longint ONE_W = longint'(1) << FRAC_W;
  localparam longint Q_MAX = (longint'(1) << FRAC_S) - 1;
  localparam longint Q_MIN = -(longint'(1) << FRAC_S);
  localparam logic [1:0] REG_NONE = 2'd3;   // unmapped register slot
  localparam int QUIET_LIMIT = 2000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 110;

  typedef struct {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [SB-1:0] sample_left = '0;
  logic signed [SB-1:0] sample_right = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [SB-1:0] out_left;
  logic signed [SB-1:0] out_right;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ssd_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [ssd_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [ssd_pkg::DATA_BITS-1:0] prdata;
  logic                 pready;

  // predictor copy of the registers and generator states
  logic [15:0] cfg_gain   = 16'd4096;
  logic [31:0] cfg_seed_l = 32'd2463534242;
  logic [31:0] cfg_seed_r = 32'd1812433253;
  logic [31:0] dith_l     = 32'd2463534242;
  logic [31:0] dith_r     = 32'd1812433253;

  frame_t pending_frames[$];
  frame_t expected_frames[$];

  int  errors = 0;
  int  frames_sent = 0;
  int  results_seen = 0;
  int  settings_used = 1;
  int  gain_lo = 65535;
  int  gain_hi = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;
  int  tx_gap = 0;
  int  rx_hold = 0;
  int  quiet = 0;
  bit  tx_next;
  int  rx_n;
  frame_t cur_req;
  frame_t want;

  stereo_sqrt_saturator_dither u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_left     (out_left),
    .out_right    (out_right),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk = ~clk;

  // floor square root, one root bit per pass from the top
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (longint'(1) << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // xorshift32 step: <<13, >>17, <<5
  function automatic logic [31:0] next_dither(input logic [31:0] s);
    logic [31:0] a;
    logic [31:0] b;
    a = s ^ {s[18:0], 13'b0};
    b = a ^ {17'b0, a[31:17]};
    return b ^ {b[26:0], 5'b0};
  endfunction

  // gain, clip, sqrt shaping, dither, floor and saturate for one channel;
  // st is the generator state after this frame's step
  function automatic logic signed [SB-1:0] shape_channel(input logic signed [SB-1:0] smp,
                                                         input logic [15:0] g,
                                                         input logic [31:0] st);
    longint x;
    longint prod;
    longint m;
    longint y;
    longint d;
    longint q;
    bit     neg;
    x    = longint'(smp);
    neg  = x < 0;
    prod = (neg ? -x : x) * longint'({48'b0, g});
    if (prod >= (longint'(1) << FRAC_P)) m = ONE_W;
    else m = prod >>> (FRAC_P - FRAC_W);
    y = ONE_W - longint'(floor_root(longint'(ONE_W - m) << FRAC_W));
    if (neg) y = -y;
    d = longint'({32'b0, st}) - longint'(32'h7fff_ffff);
    q = (y + (d >>> (FRAC_S + 1))) >>> OUT_SHIFT;
    if (q > Q_MAX) q = Q_MAX;
    if (q < Q_MIN) q = Q_MIN;
    return q[SB-1:0];
  endfunction

  function automatic int draw_gap(input bit calm);
    if (calm) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic void compare_field(input string what, input longint exp_v,
                                        input longint got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t mismatch %s: expected %0d got %0d", $time, what, exp_v, got_v);
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      tx_next = in_valid;
      if (in_valid && !in_stall) begin
        dith_l = next_dither(dith_l);
        dith_r = next_dither(dith_r);
        want.left  = shape_channel(sample_left, cfg_gain, dith_l);
        want.right = shape_channel(sample_right, cfg_gain, dith_r);
        expected_frames.push_back(want);
        frames_sent++;
        tx_next = 1'b0;
      end
      if (!tx_next) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
        end else if (pending_frames.size() != 0) begin
          cur_req = pending_frames.pop_front();
          sample_left  <= cur_req.left;
          sample_right <= cur_req.right;
          tx_next = 1'b1;
          tx_gap <= draw_gap(tx_calm);
        end
      end
      in_valid <= tx_next;
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_hold   <= 0;
    end else if (out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none got %0d %0d",
                 $time, out_left, out_right);
      end else begin
        want = expected_frames.pop_front();
        compare_field("out_left", want.left, out_left);
        compare_field("out_right", want.right, out_right);
        results_seen++;
      end
      rx_n = draw_gap(rx_calm);
      rx_hold   <= rx_n;
      out_stall <= (rx_n != 0);
    end else if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_stall <= (rx_hold > 1);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_frames.size() != 0 || in_valid || expected_frames.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ssd_pkg::REG_GAIN: cfg_gain = data[15:0];
      ssd_pkg::REG_SEED_LEFT: begin
        cfg_seed_l = data;
        dith_l     = data;
      end
      ssd_pkg::REG_SEED_RIGHT: begin
        cfg_seed_r = data;
        dith_r     = data;
      end
      default: ;
    endcase
  endtask

  task automatic apb_read(input logic [1:0] idx, output logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    data = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write the selected registers, then read all three back
  task automatic set_config(input logic [15:0] g, input logic [31:0] sl,
                            input logic [31:0] sr, input logic [2:0] sel);
    logic [31:0] rd;
    if (sel[0]) apb_write(ssd_pkg::REG_GAIN, {16'b0, g});
    if (sel[1]) apb_write(ssd_pkg::REG_SEED_LEFT, sl);
    if (sel[2]) apb_write(ssd_pkg::REG_SEED_RIGHT, sr);
    apb_read(ssd_pkg::REG_GAIN, rd);
    compare_field("gain readback", cfg_gain, rd[15:0]);
    apb_read(ssd_pkg::REG_SEED_LEFT, rd);
    compare_field("seed_left readback", cfg_seed_l, rd);
    apb_read(ssd_pkg::REG_SEED_RIGHT, rd);
    compare_field("seed_right readback", cfg_seed_r, rd);
    if (cfg_gain < gain_lo) gain_lo = cfg_gain;
    if (cfg_gain > gain_hi) gain_hi = cfg_gain;
    settings_used++;
    @(negedge clk);
  endtask

  task automatic queue_frame(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
    frame_t f;
    f.left  = l;
    f.right = r;
    pending_frames.push_back(f);
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    logic [SB-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: v = {1'b0, {(SB-1){1'b1}}};
          1: v = {1'b1, {(SB-1){1'b0}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
      1: begin
        v = SB'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = SB'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_seed();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd16386;
      2: return 32'hffff_ffff;
      3: return 32'($urandom_range(1, 16385));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 16'hffff;
      1: return 16'd4096;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(2048, 8192));
    endcase
  endfunction

  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: unity gain, full-scale negative clips exactly
    queue_frame(S_MAX, S_MIN);
    queue_frame(S_MIN, S_MAX);
    queue_frame(0, 0);
    queue_frame(-1, 1);
    queue_frame(1, -1);
    queue_frame(S_MAX >>> 1, -(S_MAX >>> 1));
    wait_drained();

    // maximum gain: clipping and output saturation; zero and tiny seeds
    set_config(16'hffff, 32'd0, 32'd1, 3'b111);
    queue_frame(S_MAX, S_MIN);
    queue_frame(S_MIN, S_MAX);
    queue_frame(0, 0);
    queue_frame(1, -1);
    queue_frame(24'sd4096, -24'sd4096);
    queue_frame(rand_sample(), rand_sample());
    wait_drained();

    // zero gain, seed just below the usual floor and all-ones seed
    set_config(16'd0, 32'd16385, 32'hffff_ffff, 3'b111);
    queue_frame(S_MAX, S_MIN);
    queue_frame(S_MIN, S_MAX);
    queue_frame(-1, 0);
    queue_frame(rand_sample(), rand_sample());
    wait_drained();

    // write to an unmapped slot must leave everything alone
    apb_write(REG_NONE, $urandom);
    set_config(16'd4097, 32'd16386, 32'h8000_0000, 3'b000);
    set_config(16'd4097, 32'd16386, 32'h8000_0000, 3'b111);
    queue_frame(S_MAX, S_MIN);
    queue_frame(S_MIN, S_MAX);
    queue_frame(24'sd8191, -24'sd8192);
    queue_frame(rand_sample(), rand_sample());
    wait_drained();

    // random phases, each with its own settings and idling mix
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_config(rand_gain(), rand_seed(), rand_seed(),
                 (ph == 0) ? 3'b111 : 3'($urandom_range(1, 7)));
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(PHASE_ITEMS / 4, 3 * PHASE_ITEMS / 4);
      for (int i = 0; i < n; i++) queue_frame(rand_sample(), rand_sample());
      // in the first phase and at random in later ones, the sender holds off until the block has drained
      if (ph == 0 || $urandom_range(0, 2) == 0) wait_drained();
      for (int i = n; i < PHASE_ITEMS; i++) queue_frame(rand_sample(), rand_sample());
      wait_drained();
    end

    repeat (100) @(negedge clk);
    $display("sent %0d frames, compared %0d results, over %0d register settings",
             frames_sent, results_seen, settings_used);
    $display("gain range %0d..%0d, zero and low seeds, clipping and saturation included",
             gain_lo, gain_hi);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d errors", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
